/* rtl/core/scls_pkg.sv */
// ----------------------------------------------------------------------------
// scls_pkg: shared definitions for the serial command line splitter
// Line depth, character codes, controller states and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package scls_pkg;

   // line store geometry
   localparam int LINE_DEPTH = 64;
   localparam int ADDR_W     = $clog2(LINE_DEPTH);
   localparam int CNT_W      = $clog2(LINE_DEPTH + 1);

   // payload widths
   localparam int BYTE_W  = 8;
   localparam int TOKEN_W = 6;

   // character codes
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'd10;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'd13;
   localparam logic [BYTE_W-1:0] CHAR_EQ    = 8'h3D;
   localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;

   // line status codes
   localparam logic STATUS_RETURN = 1'b0;
   localparam logic STATUS_FULL   = 1'b1;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRIME,
      ST_RUN
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic store;       // write accepted byte into the line store
      logic start;       // line finished, begin read-out
      logic full_line;   // line finished because the store filled
      logic load;        // parse read data into the pending character
      logic emit;        // move pending character into the output register
      logic emit_empty;  // emit the single empty-line item
      logic last_item;   // pending character is the final one of the line
      logic busy;        // line read-out in progress
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_return;   // incoming byte is LF or CR
      logic fill_zero;   // line store empty
      logic fill_at_end; // next stored byte fills the line store
      logic more;        // read data is a further character to emit
      logic out_free;    // output register can take an item this cycle
   } status_type;

endpackage

/* rtl/core/scls_req_if.sv */
// ----------------------------------------------------------------------------
// scls_req_if: received byte channel
// Valid/ready channel carrying one serial byte per item.
// ----------------------------------------------------------------------------
interface scls_req_if;
   logic                            valid;
   logic                            ready;
   logic [scls_pkg::BYTE_W-1:0]     rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

/* rtl/core/scls_rsp_if.sv */
// ----------------------------------------------------------------------------
// scls_rsp_if: line character channel
// Valid/ready channel carrying one tagged line character per item.
// ----------------------------------------------------------------------------
interface scls_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [scls_pkg::BYTE_W-1:0]     char_code;
   logic [scls_pkg::TOKEN_W-1:0]    token_index;
   logic                            is_separator;
   logic                            last;
   logic                            line_status;
   logic [scls_pkg::TOKEN_W-1:0]    param_count;

   modport source (output valid, output char_code, output token_index,
                   output is_separator, output last, output line_status,
                   output param_count, input ready);
   modport sink   (input valid, input char_code, input token_index,
                   input is_separator, input last, input line_status,
                   input param_count, output ready);
endinterface

/* rtl/core/serial_command_line_splitter_unit.sv */
// ----------------------------------------------------------------------------
// serial_command_line_splitter_unit: serial command line splitter
// Gathers received bytes into a line store and streams each finished line
// out one tagged character per item, splitting command and parameters.
// ----------------------------------------------------------------------------
//
//   channel    direction  handshake          payload
//   req_chan   in         valid / ready      rx_byte
//   rsp_chan   out        valid / ready      char_code, token_index,
//                                            is_separator, last,
//                                            line_status, param_count
//
// A byte that does not finish a line is taken whenever the unit is idle.
// A finished line is streamed with one read of the line store per character
// and a prime state for its registered read port; no byte is taken during read-out.
// The last item of a line sits in the output register while the next byte
// is taken. A stalled output holds the read-out in place.
// Reset clears the fill count and the output valid; the line store is not
// cleared, as only entries written for the current line are ever used.
// ----------------------------------------------------------------------------
module serial_command_line_splitter_unit (
   input  logic       clock,
   input  logic       reset,
   scls_req_if.sink   req_chan,
   scls_rsp_if.source rsp_chan
);

   scls_pkg::cmd_type                 cmd;
   scls_pkg::status_type              status;
   logic                              ram_wr_en;
   logic [scls_pkg::ADDR_W-1:0]       ram_wr_addr;
   logic [scls_pkg::BYTE_W-1:0]       ram_wr_data;
   logic                              ram_rd_en;
   logic [scls_pkg::ADDR_W-1:0]       ram_rd_addr;
   logic [scls_pkg::BYTE_W-1:0]       ram_rd_data;

   // controller
   scls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   scls_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .rx_byte     (req_chan.rx_byte),
      .status      (status),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp         (rsp_chan)
   );

   // line store
   scls_ram #(
      .WIDTH (scls_pkg::BYTE_W),
      .DEPTH (scls_pkg::LINE_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // no byte taken while a line is being read out
   a_no_req_while_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.busy |-> !req_chan.ready)
      else $error("byte accepted during line read-out");

   // a line starts only on an accepted byte
   a_start_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> (req_chan.valid && req_chan.ready))
      else $error("line started without an accepted byte");

   // read-out begins in the cycle after a line starts
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> cmd.busy)
      else $error("read-out did not follow line start");

   // the final item of a line ends the read-out
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.last_item || cmd.emit_empty) |=> (!cmd.busy && rsp_chan.valid && rsp_chan.last))
      else $error("read-out continued past the final item");

endmodule

/* rtl/core/scls_ram.sv */
// ----------------------------------------------------------------------------
// scls_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module scls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/scls_ctrl.sv */
// ----------------------------------------------------------------------------
// scls_ctrl: line splitter controller
// Decides when a byte is stored, when a line is finished and paces the
// character read-out against the output register.
// ----------------------------------------------------------------------------
module scls_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  scls_pkg::status_type status,
   output scls_pkg::cmd_type    cmd
);

   scls_pkg::state_type state_ff;
   scls_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scls_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         scls_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (status.is_return) begin
                  // empty returns are dropped
                  if (!status.fill_zero) begin
                     cmd.start = 1'b1;
                     state_in  = scls_pkg::ST_PRIME;
                  end
               end else begin
                  cmd.store = 1'b1;
                  if (status.fill_at_end) begin
                     cmd.start     = 1'b1;
                     cmd.full_line = 1'b1;
                     state_in      = scls_pkg::ST_PRIME;
                  end
               end
            end
         end
         scls_pkg::ST_PRIME: begin
            // first character is on the read port
            cmd.busy = 1'b1;
            if (status.more) begin
               cmd.load = 1'b1;
               state_in = scls_pkg::ST_RUN;
            end else if (status.out_free) begin
               cmd.emit_empty = 1'b1;
               state_in       = scls_pkg::ST_IDLE;
            end
         end
         scls_pkg::ST_RUN: begin
            cmd.busy = 1'b1;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.more) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.last_item = 1'b1;
                  state_in      = scls_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = scls_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/scls_dp.sv */
// ----------------------------------------------------------------------------
// scls_dp: line splitter datapath
// Fill count, read-out counter, token tracking, a pending character stage
// and the output register; drives the line store ports.
// ----------------------------------------------------------------------------
module scls_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  scls_pkg::cmd_type                 cmd,
   input  logic [scls_pkg::BYTE_W-1:0]       rx_byte,
   output scls_pkg::status_type              status,
   output logic                              ram_wr_en,
   output logic [scls_pkg::ADDR_W-1:0]       ram_wr_addr,
   output logic [scls_pkg::BYTE_W-1:0]       ram_wr_data,
   output logic                              ram_rd_en,
   output logic [scls_pkg::ADDR_W-1:0]       ram_rd_addr,
   input  logic [scls_pkg::BYTE_W-1:0]       ram_rd_data,
   scls_rsp_if.source                        rsp
);

   localparam logic [scls_pkg::CNT_W-1:0]   FILL_END  =
      scls_pkg::CNT_W'(scls_pkg::LINE_DEPTH - 1);
   localparam logic [scls_pkg::CNT_W-1:0]   FULL_LEN  =
      scls_pkg::CNT_W'(scls_pkg::LINE_DEPTH);
   localparam logic [scls_pkg::TOKEN_W-1:0] TOKEN_MAX = '1;
   localparam logic [scls_pkg::TOKEN_W-1:0] TOKEN_ONE =
      scls_pkg::TOKEN_W'(1);

   logic [scls_pkg::CNT_W-1:0]   fill_ff, fill_in;
   logic [scls_pkg::CNT_W-1:0]   len_ff, len_in;
   logic [scls_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [scls_pkg::CNT_W-1:0]   cnt_next;
   logic                         status_ff, status_in;
   logic [scls_pkg::TOKEN_W-1:0] tok_ff, tok_in;
   logic                         in_params_ff, in_params_in;
   logic [scls_pkg::BYTE_W-1:0]  pend_char_ff, pend_char_in;
   logic [scls_pkg::TOKEN_W-1:0] pend_tok_ff, pend_tok_in;
   logic                         pend_sep_ff, pend_sep_in;
   logic                         out_valid_ff, out_valid_in;
   logic [scls_pkg::BYTE_W-1:0]  out_char_ff, out_char_in;
   logic [scls_pkg::TOKEN_W-1:0] out_tok_ff, out_tok_in;
   logic                         out_sep_ff, out_sep_in;
   logic                         out_last_ff, out_last_in;
   logic                         out_status_ff, out_status_in;
   logic [scls_pkg::TOKEN_W-1:0] out_count_ff, out_count_in;
   logic                         is_last;

   assign cnt_next = cnt_ff + 1'b1;

   // status towards the controller
   assign status.is_return   = (rx_byte == scls_pkg::CHAR_LF) ||
                               (rx_byte == scls_pkg::CHAR_CR);
   assign status.fill_zero   = (fill_ff == '0);
   assign status.fill_at_end = (fill_ff == FILL_END);
   assign status.more        = (cnt_ff < len_ff) && (ram_rd_data != scls_pkg::CHAR_NUL);
   assign status.out_free    = !out_valid_ff || rsp.ready;

   // line store ports
   assign ram_wr_en   = cmd.store;
   assign ram_wr_addr = fill_ff[scls_pkg::ADDR_W-1:0];
   assign ram_wr_data = rx_byte;
   assign ram_rd_en   = cmd.start || cmd.load;
   assign ram_rd_addr = cmd.start ? '0 : cnt_next[scls_pkg::ADDR_W-1:0];

   // fill count
   always_comb begin
      fill_in = fill_ff;
      if (cmd.start) begin
         fill_in = '0;
      end else if (cmd.store) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   // line set-up, read-out counter and token parsing
   always_comb begin
      len_in       = len_ff;
      status_in    = status_ff;
      cnt_in       = cnt_ff;
      tok_in       = tok_ff;
      in_params_in = in_params_ff;
      pend_char_in = pend_char_ff;
      pend_tok_in  = pend_tok_ff;
      pend_sep_in  = pend_sep_ff;
      if (cmd.start) begin
         len_in       = cmd.full_line ? FULL_LEN : fill_ff;
         status_in    = cmd.full_line ? scls_pkg::STATUS_FULL : scls_pkg::STATUS_RETURN;
         cnt_in       = '0;
         tok_in       = '0;
         in_params_in = 1'b0;
      end else if (cmd.load) begin
         cnt_in      = cnt_next;
         pend_sep_in = 1'b0;
         if (!in_params_ff && ram_rd_data == scls_pkg::CHAR_EQ) begin
            // first '=' opens the parameter list
            in_params_in = 1'b1;
            tok_in       = TOKEN_ONE;
            pend_sep_in  = 1'b1;
         end else if (in_params_ff && ram_rd_data == scls_pkg::CHAR_COMMA) begin
            // comma opens the next parameter, index saturates
            tok_in      = (tok_ff == TOKEN_MAX) ? tok_ff : tok_ff + 1'b1;
            pend_sep_in = 1'b1;
         end
         pend_char_in = ram_rd_data;
         pend_tok_in  = tok_in;
      end
   end

   // output register
   assign is_last = cmd.emit_empty || cmd.last_item;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_char_in   = out_char_ff;
      out_tok_in    = out_tok_ff;
      out_sep_in    = out_sep_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      out_count_in  = out_count_ff;
      if (cmd.emit || cmd.emit_empty) begin
         out_valid_in  = 1'b1;
         out_char_in   = cmd.emit_empty ? scls_pkg::CHAR_NUL : pend_char_ff;
         out_tok_in    = cmd.emit_empty ? '0 : pend_tok_ff;
         out_sep_in    = cmd.emit_empty ? 1'b0 : pend_sep_ff;
         out_last_in   = is_last;
         out_status_in = is_last ? status_ff : 1'b0;
         out_count_in  = (cmd.last_item && in_params_ff) ? tok_ff : '0;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      len_ff        <= len_in;
      status_ff     <= status_in;
      cnt_ff        <= cnt_in;
      tok_ff        <= tok_in;
      in_params_ff  <= in_params_in;
      pend_char_ff  <= pend_char_in;
      pend_tok_ff   <= pend_tok_in;
      pend_sep_ff   <= pend_sep_in;
      out_char_ff   <= out_char_in;
      out_tok_ff    <= out_tok_in;
      out_sep_ff    <= out_sep_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
      out_count_ff  <= out_count_in;
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.char_code    = out_char_ff;
   assign rsp.token_index  = out_tok_ff;
   assign rsp.is_separator = out_sep_ff;
   assign rsp.last         = out_last_ff;
   assign rsp.line_status  = out_status_ff;
   assign rsp.param_count  = out_count_ff;

endmodule
